>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the matrix scanner modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

>>> sv/mdrl_pkg.sv
// ----------------------------------------------------------------------------
// Matrix scanner package
// Shared types and MIDI decode constants of the LED matrix scanner.
// ----------------------------------------------------------------------------
package mdrl_pkg;

    localparam int IN_W  = 24;
    localparam int OUT_W = 64;

    localparam logic [7:0] NOTE_STATUS_MASK = 8'hF0;
    localparam logic [7:0] NOTE_STATUS      = 8'h90;
    localparam logic [6:0] COLOUR_TOP_NOTE  = 7'h70;
    localparam logic [6:0] NOTE_SONG        = 7'h7B;
    localparam logic [6:0] NOTE_TOTAL       = 7'h71;
    localparam logic [6:0] NOTE_FX0         = 7'h78;
    localparam logic [6:0] NOTE_FX1         = 7'h79;
    localparam logic [6:0] NOTE_FX2         = 7'h7A;
    localparam logic [6:0] NOTE_CLEAR       = 7'h7D;
    localparam logic [2:0] COLOUR_MASK      = 3'h7;
    localparam logic [6:0] NOTE_OFFSET_RST  = 7'd49;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_event;
        logic issue_rd;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_col;
        logic out_free;
    } t_sts;

endpackage

>>> sv/mdrl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mdrl_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/mdrl_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix scanner controller
// Sequences one request: capture, execute, column scan, result load.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdrl_ctrl
    import mdrl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_LAST = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.do_event = 1'b1;
                n_state        = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.issue_rd = 1'b1;
                if (i_sts.last_col) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_ALWAYS(a_accept_exec, i_clk, i_rst_n, (i_s_valid && o_s_ready) |=> o_cmd.do_event, "accepted request not executed")
    `ASSERT_ALWAYS(a_exec_scan, i_clk, i_rst_n, o_cmd.do_event |=> o_cmd.issue_rd, "execute not followed by scan")
    `ASSERT_ALWAYS(a_load_free, i_clk, i_rst_n, o_cmd.load_out |-> i_sts.out_free, "result loaded over a waiting one")

endmodule

>>> sv/mdrl_dp.sv
// ----------------------------------------------------------------------------
// Matrix scanner datapath
// Request registers, MIDI decode, colour store, status registers, row scan
// and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdrl_dp
    import mdrl_pkg::*;
#(
    parameter int LED_ENTRIES = 64,
    parameter int ROWS        = 8,
    parameter int COLUMNS     = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata,
    input  logic [IN_W-1:0]  i_s_data,
    input  logic             i_s_user,
    input  logic             i_m_ready,
    output logic             o_m_valid,
    output logic [OUT_W-1:0] o_m_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts
);

    localparam int ADDR_W   = $clog2(LED_ENTRIES);
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int VIS_COLS = (COLUMNS < 8) ? COLUMNS : 8;
    localparam int SCAN_W   = 9;

    logic              r_req_type;
    logic [7:0]        r_status;
    logic [6:0]        r_note;
    logic [6:0]        r_vel;
    logic [6:0]        r_offset;
    logic [ROW_W-1:0]  r_row;
    logic [6:0]        r_song;
    logic [6:0]        r_total;
    logic [6:0]        r_fx0;
    logic [6:0]        r_fx1;
    logic [6:0]        r_fx2;
    logic              r_changed;
    logic [LED_ENTRIES-1:0] r_valid;
    logic [2:0]        r_col;
    logic              r_rd_pend;
    logic [2:0]        r_rd_col;
    logic              r_rd_ok;
    logic [7:0]        r_red;
    logic [7:0]        r_blue;
    logic [7:0]        r_green;
    logic [OUT_W-1:0]  r_out;
    logic              r_out_valid;

    logic              w_is_note;
    logic              w_in_range;
    logic [SCAN_W-1:0] w_wr_idx;
    logic              w_wr_en;
    logic              w_clear;
    logic [SCAN_W-1:0] w_scan_idx;
    logic              w_scan_ok;
    logic [2:0]        w_rd_data;

    assign w_is_note  = (r_status & NOTE_STATUS_MASK) == NOTE_STATUS;
    assign w_in_range = (r_note >= r_offset) && (r_note <= COLOUR_TOP_NOTE);
    assign w_wr_idx   = SCAN_W'(r_note - r_offset);
    assign w_wr_en    = i_cmd.do_event && !r_req_type && w_is_note && w_in_range
                        && (w_wr_idx < SCAN_W'(LED_ENTRIES));
    assign w_clear    = i_cmd.do_event && !r_req_type && w_is_note
                        && (r_note == NOTE_CLEAR);

    assign w_scan_idx = SCAN_W'(r_row) * SCAN_W'(COLUMNS) + SCAN_W'(r_col);
    assign w_scan_ok  = w_scan_idx < SCAN_W'(LED_ENTRIES);

    mdrl_ram #(
        .WIDTH (3),
        .DEPTH (LED_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_idx[ADDR_W-1:0]),
        .i_wdata ((r_vel[6:4]) & COLOUR_MASK),
        .i_raddr (w_scan_idx[ADDR_W-1:0]),
        .o_rdata (w_rd_data)
    );

    assign o_sts.last_col = r_col == 3'(VIS_COLS - 1);
    assign o_sts.out_free = !r_out_valid || i_m_ready;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= NOTE_OFFSET_RST;
            r_row       <= '0;
            r_song      <= '0;
            r_total     <= '0;
            r_fx0       <= '0;
            r_fx1       <= '0;
            r_fx2       <= '0;
            r_valid     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            if (i_cmd.do_event && r_req_type) begin
                if (r_row == ROW_W'(ROWS - 1)) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end
            if (i_cmd.do_event && !r_req_type && w_is_note && !w_in_range) begin
                case (r_note)
                    NOTE_SONG:  r_song  <= r_vel;
                    NOTE_TOTAL: r_total <= r_vel;
                    NOTE_FX0:   r_fx0   <= r_vel;
                    NOTE_FX1:   r_fx1   <= r_vel;
                    NOTE_FX2:   r_fx2   <= r_vel;
                    default:    ;
                endcase
            end
            if (w_clear) begin
                r_valid <= '0;
            end else if (w_wr_en) begin
                r_valid[w_wr_idx[ADDR_W-1:0]] <= 1'b1;
            end
            r_rd_pend <= i_cmd.issue_rd;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_s_user;
            r_status   <= i_s_data[7:0];
            r_note     <= i_s_data[14:8];
            r_vel      <= i_s_data[21:15];
        end
        if (i_cmd.do_event) begin
            r_changed <= !r_req_type && w_is_note && !w_in_range
                         && ((r_note == NOTE_SONG) || (r_note == NOTE_TOTAL)
                         || (r_note == NOTE_FX0) || (r_note == NOTE_FX1)
                         || (r_note == NOTE_FX2));
            r_col   <= '0;
            r_red   <= '0;
            r_blue  <= '0;
            r_green <= '0;
        end else if (i_cmd.issue_rd) begin
            r_col <= r_col + 3'd1;
        end
        r_rd_col <= r_col;
        r_rd_ok  <= w_scan_ok && r_valid[w_scan_idx[ADDR_W-1:0]];
        if (r_rd_pend) begin
            r_red[r_rd_col]   <= r_rd_ok & w_rd_data[0];
            r_blue[r_rd_col]  <= r_rd_ok & w_rd_data[1];
            r_green[r_rd_col] <= r_rd_ok & w_rd_data[2];
        end
        if (i_cmd.load_out) begin
            r_out <= {1'b0, r_changed, r_fx2, r_fx1, r_fx0, r_total, r_song,
                      r_green, r_blue, r_red, 3'(r_row)};
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out;

    `ASSERT_ALWAYS(a_pend_follows_issue, i_clk, i_rst_n, r_rd_pend |-> $past(i_cmd.issue_rd), "column read without issue")
    `ASSERT_ALWAYS(a_clear_empties, i_clk, i_rst_n, w_clear |=> (r_valid == '0), "store clear left live entries")
    `ASSERT_NEVER(a_tick_no_change, i_clk, i_rst_n, (i_cmd.do_event && r_req_type) ##1 r_changed, "scan tick flagged a display change")

endmodule

>>> sv/midi_driven_rgb_led_matrix_scanner.sv
// ----------------------------------------------------------------------------
// MIDI driven RGB LED matrix scanner
// Note messages fill a colour store and set song and effect status values;
// scan ticks step the row and each request answers with the row's columns.
//
// Channel   Port group       Content
// input     s_axis_*         tuser: request type; tdata: status, note, velocity
// output    m_axis_*         tdata: row, red, blue, green, song, total,
//                            repeat, delay, redux, display changed
// config    i_cfg_*          note offset
//
// A request's column bits come from one store read per column, and the
// result is then loaded. The next request is taken only after the load. The
// store is usable right after reset; per-entry valid flags stand in for a
// clearing pass, and a clear note resets them all. A result waits in the
// output register while the next request is taken in, and the load stalls
// while an earlier result is still waiting.
// ----------------------------------------------------------------------------
module midi_driven_rgb_led_matrix_scanner
    import mdrl_pkg::*;
#(
    parameter int LED_ENTRIES = 64,
    parameter int ROWS        = 8,
    parameter int COLUMNS     = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // Bits from low: status_byte[7:0], note_number[14:8], velocity[21:15], zeros.
    input  logic [IN_W-1:0]  s_axis_tdata,
    // Bit 0: req_type.
    input  logic [0:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // Bits from low: row_select[2:0], red_columns[10:3], blue_columns[18:11],
    // green_columns[26:19], song_now[33:27], song_total[40:34],
    // repeat_status[47:41], delay_status[54:48], redux_status[61:55],
    // display_changed[62], zero.
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    mdrl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    mdrl_dp #(
        .LED_ENTRIES (LED_ENTRIES),
        .ROWS        (ROWS),
        .COLUMNS     (COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_data    (s_axis_tdata),
        .i_s_user    (s_axis_tuser[0]),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule
